// ----- rtl/hbe_pkg.sv -----
package hbe_pkg;

    localparam int MAX_BINS    = 256;
    localparam int BIN_BITS    = 8;
    localparam int NB_BITS     = 9;
    localparam int COUNT_BITS  = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int PCT_BITS    = 14;
    localparam int MID_BITS    = 24;
    localparam int DIV_BITS    = 32;
    localparam int DVSR_BITS   = 16;
    localparam int CUM_BITS    = COUNT_BITS + BIN_BITS + 1;
    localparam int PT_BITS     = PCT_BITS + COUNT_BITS;
    localparam int CUMX_BITS   = CUM_BITS + PCT_BITS;

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_REMOVE  = 3'd1;
    localparam logic [2:0] OP_CLEAR   = 3'd2;
    localparam logic [2:0] OP_PCT     = 3'd3;
    localparam logic [2:0] OP_MODE    = 3'd4;
    localparam logic [2:0] OP_LARGEST = 3'd5;
    localparam logic [2:0] OP_READ    = 3'd6;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_DATA    = 2'd1;
    localparam logic [1:0] ST_BIN_UNUSED = 2'd2;
    localparam logic [1:0] ST_EMPTY_BIN  = 2'd3;

    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_END   = 2'd1;
    localparam logic [1:0] CFG_BINS  = 2'd2;

    localparam logic [PCT_BITS-1:0] PCT_FULL = 14'd10000;

    typedef struct packed {
        logic [2:0]                    opcode;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          sample_valid;
        logic [PCT_BITS-1:0]           percent_hundredths;
        logic [BIN_BITS-1:0]           bin_select;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] range_start;
        logic signed [SAMPLE_BITS-1:0] range_end;
        logic [NB_BITS-1:0]            bins_in_use;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                 status;
        logic [BIN_BITS-1:0]        bin_index;
        logic signed [MID_BITS-1:0] bin_middle;
        logic [COUNT_BITS-1:0]      bin_count;
    } result_t;

endpackage

// ----- rtl/hbe_front.sv -----
module hbe_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [39:0]    s_tdata,
    input  logic [3:0]     s_tuser,
    output logic           q_valid,
    output hbe_pkg::item_t q_item,
    input  logic           q_pop
);

    hbe_pkg::item_t slot_reg [2];
    logic [1:0]     fill_reg;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    hbe_pkg::item_t in_item;
    logic           push;
    logic           pop;

    always_comb
    begin
        in_item.opcode             = s_tuser[2:0];
        in_item.sample_valid       = s_tuser[3];
        in_item.sample             = s_tdata[15:0];
        in_item.percent_hundredths = s_tdata[29:16];
        in_item.bin_select         = s_tdata[37:30];
    end

    assign s_tready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid & s_tready;
    assign pop      = q_pop & q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

// ----- rtl/hbe_div.sv -----
module hbe_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [hbe_pkg::DIV_BITS-1:0]  dividend,
    input  logic [hbe_pkg::DVSR_BITS-1:0] divisor,
    output logic                          done,
    output logic [hbe_pkg::DIV_BITS-1:0]  quotient
);

    logic [hbe_pkg::DIV_BITS-1:0]  quo_reg;
    logic [hbe_pkg::DVSR_BITS-1:0] rem_reg;
    logic [hbe_pkg::DVSR_BITS-1:0] dvsr_reg;
    logic [5:0]                    step_reg;
    logic                          done_reg;
    logic [hbe_pkg::DVSR_BITS:0]   shifted;
    logic                          fits;

    // Restoring division, one quotient bit per cycle.
    assign shifted  = {rem_reg, quo_reg[hbe_pkg::DIV_BITS-1]};
    assign fits     = (shifted >= {1'b0, dvsr_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end
        else if (step_reg != 6'd0)
        begin
            quo_reg <= {quo_reg[hbe_pkg::DIV_BITS-2:0], fits};
            rem_reg <= fits ? hbe_pkg::DVSR_BITS'(shifted - {1'b0, dvsr_reg})
                            : shifted[hbe_pkg::DVSR_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 6'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (step_reg == 6'd1);
            if (start)
            begin
                step_reg <= 6'(hbe_pkg::DIV_BITS);
            end
            else if (step_reg != 6'd0)
            begin
                step_reg <= step_reg - 6'd1;
            end
        end
    end

endmodule

// ----- rtl/hbe_back.sv -----
module hbe_back (
    input  logic             clk,
    input  logic             rst_n,
    input  hbe_pkg::cfg_t    cfg,
    input  logic             q_valid,
    input  hbe_pkg::item_t   q_item,
    output logic             q_pop,
    output logic             out_valid,
    output hbe_pkg::result_t out_res,
    input  logic             out_ready
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DEC    = 13'b0000000000010,
        S_BDIV   = 13'b0000000000100,
        S_BRD    = 13'b0000000001000,
        S_BUPD   = 13'b0000000010000,
        S_MSTART = 13'b0000000100000,
        S_MDIV   = 13'b0000001000000,
        S_PRD    = 13'b0000010000000,
        S_PACC   = 13'b0000100000000,
        S_PCMP   = 13'b0001000000000,
        S_MRD    = 13'b0010000000000,
        S_MCMP   = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } state_t;

    localparam int CB = hbe_pkg::COUNT_BITS;
    localparam int BB = hbe_pkg::BIN_BITS;
    localparam logic signed [33:0] MID_HI = 34'sd8388607;
    localparam logic signed [33:0] MID_LO = -34'sd8388608;

    state_t                           state_reg, state_next;
    hbe_pkg::item_t                   item_reg, item_next;
    hbe_pkg::result_t                 res_reg, res_next;
    hbe_pkg::result_t                 out_reg;
    logic                             out_valid_reg;
    logic [BB-1:0]                    b_reg, b_next;
    logic [BB-1:0]                    idx_reg, idx_next;
    logic [1:0]                       stat_reg, stat_next;
    logic [CB-1:0]                    cnt_reg, cnt_next;
    logic [CB-1:0]                    total_reg, total_next;
    logic [hbe_pkg::CUM_BITS-1:0]     cum_reg, cum_next;
    logic [hbe_pkg::PT_BITS-1:0]      pt_reg, pt_next;
    logic [hbe_pkg::MAX_BINS-1:0]     vbits_reg;
    logic                             vclear;
    logic [CB-1:0]                    mem [hbe_pkg::MAX_BINS];
    logic [CB-1:0]                    rd_data_reg;
    logic                             rd_vld_reg;
    logic [BB-1:0]                    rd_addr;
    logic                             we;
    logic [CB-1:0]                    wdata;

    logic                             div_start;
    logic [hbe_pkg::DIV_BITS-1:0]     div_dividend;
    logic [hbe_pkg::DVSR_BITS-1:0]    div_divisor;
    logic                             div_done;
    logic [hbe_pkg::DIV_BITS-1:0]     div_q;

    logic [hbe_pkg::NB_BITS-1:0]      nb;
    logic [BB-1:0]                    last_bin;
    logic signed [16:0]               span_full;
    logic [15:0]                      span;
    logic signed [16:0]               diff;
    logic signed [26:0]               num;
    logic                             in_range;
    logic [hbe_pkg::PCT_BITS-1:0]     pct_c;
    logic [CB-1:0]                    rd_cnt;
    logic [24:0]                      mprod;
    logic signed [33:0]               mid_sum;
    logic signed [hbe_pkg::MID_BITS-1:0] mid_sat;
    logic [hbe_pkg::CUMX_BITS-1:0]    cum_x;
    logic                             reached;
    logic                             better;
    logic [CB-1:0]                    best_c;
    logic [BB-1:0]                    best_b;
    logic [hbe_pkg::DIV_BITS-1:0]     bq;

    hbe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        if (cfg.bins_in_use == '0)
        begin
            nb = 9'd1;
        end
        else if (cfg.bins_in_use > 9'(hbe_pkg::MAX_BINS))
        begin
            nb = 9'(hbe_pkg::MAX_BINS);
        end
        else
        begin
            nb = cfg.bins_in_use;
        end
    end

    assign last_bin  = BB'(nb - 9'd1);
    assign span_full = {cfg.range_end[15], cfg.range_end}
                     - {cfg.range_start[15], cfg.range_start};
    assign span      = span_full[16] ? 16'd0 : span_full[15:0];
    assign diff      = {item_reg.sample[15], item_reg.sample}
                     - {cfg.range_start[15], cfg.range_start};
    assign num       = diff * $signed({1'b0, nb});
    assign in_range  = (item_reg.sample >= cfg.range_start)
                     && (item_reg.sample <= cfg.range_end);
    assign pct_c     = (item_reg.percent_hundredths > hbe_pkg::PCT_FULL)
                     ? hbe_pkg::PCT_FULL : item_reg.percent_hundredths;
    assign rd_cnt    = rd_vld_reg ? rd_data_reg : '0;
    assign mprod     = span * {b_reg, 1'b1};
    assign mid_sum   = $signed({{10{cfg.range_start[15]}}, cfg.range_start, 8'b0})
                     + $signed({2'b0, div_q});
    assign mid_sat   = (mid_sum > MID_HI) ? 24'sh7FFFFF
                     : (mid_sum < MID_LO) ? 24'sh800000 : mid_sum[23:0];
    assign cum_x     = hbe_pkg::CUMX_BITS'(cum_reg) * hbe_pkg::CUMX_BITS'(hbe_pkg::PCT_FULL);
    assign reached   = (cum_x >= hbe_pkg::CUMX_BITS'(pt_reg));
    // The first bin of a mode scan always takes the lead; later ones only when larger.
    assign better    = (idx_reg == '0) || (rd_cnt > cnt_reg);
    assign best_c    = better ? rd_cnt : cnt_reg;
    assign best_b    = better ? idx_reg : b_reg;
    assign bq        = div_q;

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        res_next     = res_reg;
        b_next       = b_reg;
        idx_next     = idx_reg;
        stat_next    = stat_reg;
        cnt_next     = cnt_reg;
        total_next   = total_reg;
        cum_next     = cum_reg;
        pt_next      = pt_reg;
        vclear       = 1'b0;
        q_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = hbe_pkg::DIV_BITS'(num[25:0]);
        div_divisor  = span;
        we           = 1'b0;
        wdata        = '0;
        rd_addr      = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                res_next   = '0;
                state_next = S_OUT;
                case (item_reg.opcode)
                    hbe_pkg::OP_ADD, hbe_pkg::OP_REMOVE:
                    begin
                        if (!item_reg.sample_valid
                            || (item_reg.opcode == hbe_pkg::OP_ADD && !in_range))
                        begin
                            res_next.status = hbe_pkg::ST_NO_DATA;
                        end
                        else if (span == 16'd0 || num < 0)
                        begin
                            b_next     = '0;
                            state_next = S_BRD;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_BDIV;
                        end
                    end
                    hbe_pkg::OP_CLEAR:
                    begin
                        vclear     = 1'b1;
                        total_next = '0;
                    end
                    hbe_pkg::OP_PCT:
                    begin
                        if (total_reg == '0)
                        begin
                            res_next.status = hbe_pkg::ST_NO_DATA;
                        end
                        else
                        begin
                            pt_next    = hbe_pkg::PT_BITS'(pct_c)
                                       * hbe_pkg::PT_BITS'(total_reg);
                            cum_next   = '0;
                            idx_next   = '0;
                            state_next = S_PRD;
                        end
                    end
                    hbe_pkg::OP_MODE, hbe_pkg::OP_LARGEST:
                    begin
                        idx_next   = '0;
                        b_next     = '0;
                        cnt_next   = '0;
                        state_next = S_MRD;
                    end
                    hbe_pkg::OP_READ:
                    begin
                        if ({1'b0, item_reg.bin_select} >= nb)
                        begin
                            res_next.status = hbe_pkg::ST_BIN_UNUSED;
                        end
                        else
                        begin
                            b_next     = item_reg.bin_select;
                            state_next = S_BRD;
                        end
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end
            S_BDIV:
            begin
                if (div_done)
                begin
                    b_next     = (bq >= hbe_pkg::DIV_BITS'(nb)) ? last_bin : bq[BB-1:0];
                    state_next = S_BRD;
                end
            end
            S_BRD:
            begin
                rd_addr    = b_reg;
                state_next = S_BUPD;
            end
            S_BUPD:
            begin
                stat_next  = hbe_pkg::ST_OK;
                state_next = S_MSTART;
                case (item_reg.opcode)
                    hbe_pkg::OP_ADD:
                    begin
                        cnt_next = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
                        we       = 1'b1;
                        wdata    = cnt_next;
                        if (total_reg != '1)
                        begin
                            total_next = total_reg + 1'b1;
                        end
                    end
                    hbe_pkg::OP_REMOVE:
                    begin
                        if (rd_cnt == '0)
                        begin
                            stat_next = hbe_pkg::ST_EMPTY_BIN;
                            cnt_next  = '0;
                        end
                        else
                        begin
                            cnt_next = rd_cnt - 1'b1;
                            we       = 1'b1;
                            wdata    = cnt_next;
                            if (total_reg != '0)
                            begin
                                total_next = total_reg - 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        cnt_next = rd_cnt;
                    end
                endcase
            end
            S_MSTART:
            begin
                div_start    = 1'b1;
                div_dividend = {mprod, 7'b0};
                div_divisor  = hbe_pkg::DVSR_BITS'(nb);
                state_next   = S_MDIV;
            end
            S_MDIV:
            begin
                if (div_done)
                begin
                    res_next.status     = stat_reg;
                    res_next.bin_index  = b_reg;
                    res_next.bin_middle = mid_sat;
                    res_next.bin_count  = cnt_reg;
                    state_next          = S_OUT;
                end
            end
            S_PRD:
            begin
                state_next = S_PACC;
            end
            S_PACC:
            begin
                cum_next   = cum_reg + hbe_pkg::CUM_BITS'(rd_cnt);
                cnt_next   = rd_cnt;
                state_next = S_PCMP;
            end
            S_PCMP:
            begin
                if (reached || idx_reg == last_bin)
                begin
                    b_next     = idx_reg;
                    stat_next  = hbe_pkg::ST_OK;
                    state_next = S_MSTART;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_PRD;
                end
            end
            S_MRD:
            begin
                state_next = S_MCMP;
            end
            S_MCMP:
            begin
                b_next   = best_b;
                cnt_next = best_c;
                if (idx_reg == last_bin)
                begin
                    res_next   = '0;
                    state_next = S_OUT;
                    if (item_reg.opcode == hbe_pkg::OP_LARGEST)
                    begin
                        res_next.bin_count = best_c;
                    end
                    else if (best_c == '0)
                    begin
                        res_next.status = hbe_pkg::ST_NO_DATA;
                    end
                    else
                    begin
                        stat_next  = hbe_pkg::ST_OK;
                        state_next = S_MSTART;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_MRD;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[b_reg] <= wdata;
        end
        rd_data_reg <= mem[rd_addr];
        item_reg    <= item_next;
        res_reg     <= res_next;
        b_reg       <= b_next;
        idx_reg     <= idx_next;
        stat_reg    <= stat_next;
        cnt_reg     <= cnt_next;
        cum_reg     <= cum_next;
        pt_reg      <= pt_next;
        if (state_reg == S_OUT && (!out_valid_reg || out_ready))
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            vbits_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            rd_vld_reg <= vbits_reg[rd_addr];
            if (vclear)
            begin
                vbits_reg <= '0;
            end
            else if (we)
            begin
                vbits_reg[b_reg] <= 1'b1;
            end
            if (state_reg == S_OUT && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

// ----- rtl/histogram_bin_engine.sv -----
// Uniform-bin histogram over [range_start, range_end] split into bins_in_use
// bins, with add, remove, clear and percentile, mode, largest-count and
// read-bin queries; every item gives exactly one result. Items enter a
// two-deep queue and are then worked one at a time by a sequencer around a
// count memory (one read, one write port) and one shared 32-step divider.
// Clear, rejected items and read-bin errors skip the divider. Read bin,
// percentile and a nonzero mode divide for the bin middle; add and remove
// do too, after a divide for the bin index unless the span is zero or the
// sample is below range_start. Percentile reads bins until its target;
// mode and largest count read each bin in use. Bins come out of reset and
// clear at zero at once, with no clearing pass. A finished result waits in
// the output register while the queue keeps taking items.
module histogram_bin_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // sample[15:0], percent_hundredths[29:16], bin_select[37:30]
    input  logic [3:0]  s_tuser,  // opcode[2:0], sample_valid[3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // bin_index[7:0], bin_middle[31:8], bin_count[63:32]
    output logic [1:0]  m_tuser,  // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    hbe_pkg::cfg_t    cfg_reg;
    hbe_pkg::item_t   q_item;
    hbe_pkg::result_t res;
    logic             q_valid;
    logic             q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_start <= 16'sd0;
            cfg_reg.range_end   <= 16'sd255;
            cfg_reg.bins_in_use <= 9'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hbe_pkg::CFG_START: cfg_reg.range_start <= cfg_data;
                hbe_pkg::CFG_END:   cfg_reg.range_end   <= cfg_data;
                hbe_pkg::CFG_BINS:  cfg_reg.bins_in_use <= cfg_data[8:0];
                default:            cfg_reg             <= cfg_reg;
            endcase
        end
    end

    hbe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    hbe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_res   (res),
        .out_ready (m_tready)
    );

    assign m_tdata = {res.bin_count, res.bin_middle, res.bin_index};
    assign m_tuser = res.status;

endmodule

// ----- rtl/hbe_checker.sv -----
module hbe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A held result must not change until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    a_nodata: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == hbe_pkg::ST_NO_DATA |-> m_tdata == 64'd0)
        else $error("no-data result carries nonzero fields");

    a_unused: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == hbe_pkg::ST_BIN_UNUSED |-> m_tdata == 64'd0)
        else $error("unused-bin result carries nonzero fields");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == hbe_pkg::ST_EMPTY_BIN |-> m_tdata[63:32] == 32'd0)
        else $error("empty-bin remove reports a nonzero count");

endmodule

bind histogram_bin_engine hbe_checker u_hbe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- bench/histogram_bin_engine_tb.sv -----
`timescale 1ns / 1ps

module histogram_bin_engine_tb;

    localparam longint CNT_MAX = 64'hFFFF_FFFF;
    localparam int CYCLE_LIMIT = 20_000_000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // sample, percent_hundredths, bin_select
    logic [3:0]  s_tuser;   // opcode, sample_valid
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // bin_index, bin_middle, bin_count
    logic [1:0]  m_tuser;   // status
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int send_idle_pct;
    int recv_stall_pct;
    int cycles;

    histogram_bin_engine DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Histogram predictor with its own copy of the bins and registers.
    class hist_scoreboard;
        longint                   counts[hbe_pkg::MAX_BINS];
        longint                   total;
        logic [15:0]              reg_start;
        logic [15:0]              reg_end;
        logic [8:0]               reg_bins;
        hbe_pkg::result_t         pending[$];
        int                       errors;

        function new();
            foreach (counts[i]) counts[i] = 0;
            total = 0;
            reg_start = 16'd0;
            reg_end = 16'd255;
            reg_bins = 9'd256;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == hbe_pkg::CFG_START) reg_start = val;
            else if (idx == hbe_pkg::CFG_END) reg_end = val;
            else if (idx == hbe_pkg::CFG_BINS) reg_bins = val[8:0];
        endfunction

        function longint bins_used();
            longint n;
            n = longint'(reg_bins);
            if (n == 0) n = 1;
            if (n > hbe_pkg::MAX_BINS) n = hbe_pkg::MAX_BINS;
            return n;
        endfunction

        function longint span();
            longint s;
            s = longint'($signed(reg_end)) - longint'($signed(reg_start));
            return (s < 0) ? 0 : s;
        endfunction

        function int bin_for(longint x);
            longint num, idx;
            if (span() == 0) return 0;
            num = (x - longint'($signed(reg_start))) * bins_used();
            if (num < 0) return 0;
            idx = num / span();
            if (idx >= bins_used()) idx = bins_used() - 1;
            return int'(idx);
        endfunction

        function logic [23:0] middle(int i);
            longint m;
            m = longint'($signed(reg_start)) * 256
                + (span() * longint'(2 * i + 1) * 128) / bins_used();
            if (m > 8388607) m = 8388607;
            if (m < -8388608) m = -8388608;
            return m[23:0];
        endfunction

        function hbe_pkg::result_t found(int b);
            hbe_pkg::result_t r;
            r = '0;
            r.bin_index = b[7:0];
            r.bin_middle = middle(b);
            r.bin_count = counts[b][31:0];
            return r;
        endfunction

        function void note_item(hbe_pkg::item_t it);
            hbe_pkg::result_t r;
            longint x, cum, pct, nb;
            int b;
            r = '0;
            x = longint'(it.sample);
            nb = bins_used();
            case (it.opcode) inside
                hbe_pkg::OP_ADD:
                    if (!it.sample_valid || x < longint'($signed(reg_start))
                        || x > longint'($signed(reg_end)))
                        r.status = hbe_pkg::ST_NO_DATA;
                    else
                    begin
                        b = bin_for(x);
                        if (counts[b] < CNT_MAX) counts[b]++;
                        if (total < CNT_MAX) total++;
                        r = found(b);
                    end
                hbe_pkg::OP_REMOVE:
                    if (!it.sample_valid)
                        r.status = hbe_pkg::ST_NO_DATA;
                    else
                    begin
                        b = bin_for(x);
                        if (counts[b] == 0)
                        begin
                            r = found(b);
                            r.status = hbe_pkg::ST_EMPTY_BIN;
                        end
                        else
                        begin
                            counts[b]--;
                            if (total > 0) total--;
                            r = found(b);
                        end
                    end
                hbe_pkg::OP_CLEAR:
                begin
                    foreach (counts[i]) counts[i] = 0;
                    total = 0;
                end
                hbe_pkg::OP_PCT:
                    if (total == 0)
                        r.status = hbe_pkg::ST_NO_DATA;
                    else
                    begin
                        pct = longint'(it.percent_hundredths);
                        if (pct > hbe_pkg::PCT_FULL) pct = hbe_pkg::PCT_FULL;
                        b = int'(nb - 1);
                        cum = 0;
                        for (int i = 0; i < nb; i++)
                        begin
                            cum += counts[i];
                            if (cum * 10000 >= pct * total)
                            begin
                                b = i;
                                break;
                            end
                        end
                        r = found(b);
                    end
                hbe_pkg::OP_MODE, hbe_pkg::OP_LARGEST:
                begin
                    b = 0;
                    for (int i = 1; i < nb; i++)
                        if (counts[i] > counts[b]) b = i;
                    if (it.opcode == hbe_pkg::OP_LARGEST)
                        r.bin_count = counts[b][31:0];
                    else if (counts[b] == 0)
                        r.status = hbe_pkg::ST_NO_DATA;
                    else
                        r = found(b);
                end
                hbe_pkg::OP_READ:
                    if (longint'(it.bin_select) >= nb)
                        r.status = hbe_pkg::ST_BIN_UNUSED;
                    else
                        r = found(int'(it.bin_select));
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(hbe_pkg::result_t got);
            hbe_pkg::result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: result with none expected: status %0d index %0d",
                         $time, got.status, got.bin_index);
                $display("%0t: middle %0h count %0d", $time, got.bin_middle, got.bin_count);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.bin_index !== want.bin_index)
            begin
                $display("%0t: bin_index expected %0d actual %0d", $time,
                         want.bin_index, got.bin_index);
                errors++;
            end
            if (got.bin_middle !== want.bin_middle)
            begin
                $display("%0t: bin_middle expected %0h actual %0h", $time,
                         want.bin_middle, got.bin_middle);
                errors++;
            end
            if (got.bin_count !== want.bin_count)
            begin
                $display("%0t: bin_count expected %0d actual %0d", $time,
                         want.bin_count, got.bin_count);
                errors++;
            end
        endfunction
    endclass

    hist_scoreboard board;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Output side: random stalls, checks every accepted result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_result({m_tuser, m_tdata[7:0], m_tdata[31:8], m_tdata[63:32]});
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The valid line stays high between items that follow with no gap.
    task automatic send_item(hbe_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, it.bin_select, it.percent_hundredths, it.sample};
        s_tuser <= {it.sample_valid, it.opcode};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_item(it);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_range(int lo, int hi, int nbins);
        drain();
        write_reg(hbe_pkg::CFG_START, lo[15:0]);
        write_reg(hbe_pkg::CFG_END, hi[15:0]);
        write_reg(hbe_pkg::CFG_BINS, nbins[15:0]);
    endtask

    function automatic hbe_pkg::item_t make_item(logic [2:0] op, int x, bit ok, int pct,
                                                 int sel);
        hbe_pkg::item_t it;
        it.opcode = op;
        it.sample = x[15:0];
        it.sample_valid = ok;
        it.percent_hundredths = pct[13:0];
        it.bin_select = sel[7:0];
        return it;
    endfunction

    // Mostly adds and removes near the configured range, with queries mixed in.
    function automatic hbe_pkg::item_t random_item();
        hbe_pkg::item_t it;
        int r, lo, hi;
        r = int'($urandom_range(99));
        lo = int'($signed(board.reg_start));
        hi = int'($signed(board.reg_end));
        it = make_item(hbe_pkg::OP_ADD, 0, 1'b1, int'($urandom_range(10000)),
                       int'($urandom_range(255)));
        it.sample = 16'($urandom);
        if (r < 60)
        begin
            if ($urandom_range(9) != 0 && hi >= lo)
                it.sample = 16'(lo + int'($urandom_range(hi - lo)));
            it.sample_valid = ($urandom_range(19) != 0);
            it.opcode = (r < 45) ? hbe_pkg::OP_ADD : hbe_pkg::OP_REMOVE;
        end
        else if (r < 61)
            it.opcode = hbe_pkg::OP_CLEAR;
        else if (r < 98)
            it.opcode = 3'($urandom_range(hbe_pkg::OP_PCT, hbe_pkg::OP_READ));
        else
            it.opcode = 3'd7;
        if ($urandom_range(9) == 0)
            it.percent_hundredths = 14'($urandom);
        it.sample_valid = (r >= 60) ? 1'($urandom) : it.sample_valid;
        return it;
    endfunction

    initial
    begin
        int phase;
        board = new();
        cycles = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queries, reset range, extremes of every field.
        send_item(make_item(hbe_pkg::OP_PCT, 0, 1, 5000, 0));
        send_item(make_item(hbe_pkg::OP_MODE, 0, 1, 0, 0));
        send_item(make_item(hbe_pkg::OP_LARGEST, 0, 1, 0, 0));
        send_item(make_item(hbe_pkg::OP_REMOVE, 7, 1, 0, 0));
        send_item(make_item(hbe_pkg::OP_ADD, 0, 1, 0, 0));
        send_item(make_item(hbe_pkg::OP_ADD, 255, 1, 0, 0));
        send_item(make_item(hbe_pkg::OP_ADD, 256, 1, 0, 0));
        send_item(make_item(hbe_pkg::OP_ADD, -32768, 1, 0, 0));
        send_item(make_item(hbe_pkg::OP_ADD, 32767, 1, 0, 0));
        send_item(make_item(hbe_pkg::OP_ADD, 100, 0, 0, 0));
        send_item(make_item(hbe_pkg::OP_PCT, 0, 1, 0, 0));
        send_item(make_item(hbe_pkg::OP_PCT, 0, 1, 10000, 0));
        send_item(make_item(hbe_pkg::OP_PCT, 0, 1, 16383, 0));
        send_item(make_item(hbe_pkg::OP_MODE, 0, 1, 0, 0));
        send_item(make_item(hbe_pkg::OP_LARGEST, 0, 1, 0, 0));
        send_item(make_item(hbe_pkg::OP_READ, 0, 1, 0, 255));
        send_item(make_item(hbe_pkg::OP_REMOVE, 0, 0, 0, 0));
        send_item(make_item(hbe_pkg::OP_REMOVE, 255, 1, 0, 0));
        send_item(make_item(3'd7, -1, 1, 16383, 255));
        send_item(make_item(hbe_pkg::OP_CLEAR, 0, 1, 0, 0));
        send_item(make_item(hbe_pkg::OP_READ, 0, 1, 0, 0));

        set_range(-32768, 32767, 511);
        send_item(make_item(hbe_pkg::OP_ADD, -32768, 1, 0, 0));
        send_item(make_item(hbe_pkg::OP_ADD, 32767, 1, 0, 0));
        send_item(make_item(hbe_pkg::OP_READ, 0, 1, 0, 200));
        set_range(-5, -5, 0);
        send_item(make_item(hbe_pkg::OP_ADD, -5, 1, 0, 0));
        send_item(make_item(hbe_pkg::OP_READ, 0, 1, 0, 1));
        set_range(10, -10, 1);
        send_item(make_item(hbe_pkg::OP_ADD, 0, 1, 0, 0));
        send_item(make_item(hbe_pkg::OP_REMOVE, 0, 1, 0, 0));

        // Random phases over several ranges and idling patterns.
        for (phase = 0; phase < 12; phase++)
        begin
            case (phase % 6)
                0: set_range(0, 255, 256);
                1: set_range(-32768, 32767, int'($urandom_range(1, 256)));
                2: set_range(-100, 100, int'($urandom_range(1, 16)));
                3: set_range(-7, 7, 511);
                4: set_range(1000, 1000, int'($urandom_range(0, 8)));
                default: set_range(-20, 40, 3);
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            repeat (160) send_item(random_item());
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        send_item(make_item(hbe_pkg::OP_CLEAR, 0, 1, 0, 0));
        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/hbe_pkg.sv
rtl/hbe_front.sv
rtl/hbe_div.sv
rtl/hbe_back.sv
rtl/histogram_bin_engine.sv
rtl/hbe_checker.sv
bench/histogram_bin_engine_tb.sv
